/* rtl/jvpt_pkg.sv */
package jvpt_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	// both queues hold two entries
	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	typedef enum logic [2:0] {
		CL_END,
		CL_DOT,
		CL_LBRACK,
		CL_RBRACK,
		CL_KEY,
		CL_OTHER
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [7:0]  ch;
	} token_t;

	typedef enum logic [2:0] {
		ST_EMPTY_ROOT = 3'd0,
		ST_DOT_ROOT   = 3'd1,
		ST_PART_ARRAY = 3'd2,
		ST_FULL_ARRAY = 3'd3,
		ST_START_KEY  = 3'd4,
		ST_WITHIN_KEY = 3'd5
	} parse_state_t;

	typedef enum logic [2:0] {
		ERR_NONE          = 3'd0,
		ERR_FIRST_NOT_DOT = 3'd1,
		ERR_AFTER_ROOT    = 3'd2,
		ERR_NO_CLOSE      = 3'd3,
		ERR_AFTER_ARRAY   = 3'd4,
		ERR_KEY_EXPECTED  = 3'd5,
		ERR_BAD_KEY_CHAR  = 3'd6
	} err_code_t;

	typedef struct packed {
		logic       key_byte_valid;
		logic [7:0] key_char;
		logic       key_done;
		logic       array_segment;
		logic       path_done;
		err_code_t  error_code;
	} result_t;

	// ']' falls in the key byte range; CL_RBRACK also counts as a key byte
	function automatic char_class_t classify(input logic is_end, input logic [7:0] c);
		char_class_t cls;
		if (is_end) begin
			cls = CL_END;
		end else if (c == CH_DOT) begin
			cls = CL_DOT;
		end else if (c == CH_LBRACK) begin
			cls = CL_LBRACK;
		end else if (c == CH_RBRACK) begin
			cls = CL_RBRACK;
		end else if (c > CH_SPACE && c <= CH_TILDE && c != CH_BSLASH && c != CH_QUOTE) begin
			cls = CL_KEY;
		end else begin
			cls = CL_OTHER;
		end
		return cls;
	endfunction

endpackage

/* rtl/jvpt_front.sv */
module jvpt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       in_byte,
	input  logic             path_end,
	output jvpt_pkg::token_t tok,
	output logic             tok_valid,
	input  logic             tok_take
);
	import jvpt_pkg::*;

	token_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr;

	assign full      = (cnt_q == QUEUE_DEPTH);
	assign wr        = push && !full;
	assign tok_valid = (cnt_q != 2'd0);
	assign tok       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= '{cls: classify(path_end, in_byte), ch: in_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (tok_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr, tok_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/jvpt_back.sv */
module jvpt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jvpt_pkg::token_t tok,
	input  logic             tok_valid,
	output logic             tok_take,
	output logic             empty,
	input  logic             pop,
	output jvpt_pkg::result_t res_out
);
	import jvpt_pkg::*;

	parse_state_t state_q, state_d;
	err_code_t    held_q, held_d;
	result_t      res;
	result_t      oq_q [2];
	logic         owr_ptr_q;
	logic         ord_ptr_q;
	logic [1:0]   ocnt_q;
	logic         rd;
	logic         is_end;
	logic         key_ok;

	assign is_end   = (tok.cls == CL_END);
	assign key_ok   = (tok.cls == CL_KEY) || (tok.cls == CL_RBRACK);
	assign tok_take = tok_valid && (ocnt_q != QUEUE_DEPTH);
	assign empty    = (ocnt_q == 2'd0);
	assign rd       = pop && !empty;
	assign res_out  = oq_q[ord_ptr_q];

	// result of the current head token
	always_comb begin
		res = '0;
		if (held_q != ERR_NONE) begin
			res.error_code = held_q;
			res.path_done  = is_end;
		end else begin
			unique case (state_q)
				ST_DOT_ROOT: begin
					if (is_end) begin
						res.path_done = 1'b1;
					end else if (tok.cls == CL_LBRACK) begin
						res.path_done = 1'b0;
					end else if (key_ok) begin
						res.key_byte_valid = 1'b1;
						res.key_char       = tok.ch;
					end else begin
						res.error_code = ERR_AFTER_ROOT;
					end
				end
				ST_PART_ARRAY: begin
					if (tok.cls == CL_RBRACK) begin
						res.array_segment = 1'b1;
					end else begin
						res.error_code = ERR_NO_CLOSE;
					end
				end
				ST_FULL_ARRAY: begin
					if (is_end) begin
						res.path_done = 1'b1;
					end else if (tok.cls != CL_DOT && tok.cls != CL_LBRACK) begin
						res.error_code = ERR_AFTER_ARRAY;
					end
				end
				ST_START_KEY: begin
					if (key_ok) begin
						res.key_byte_valid = 1'b1;
						res.key_char       = tok.ch;
					end else begin
						res.error_code = ERR_KEY_EXPECTED;
					end
				end
				ST_WITHIN_KEY: begin
					if (is_end) begin
						res.key_done  = 1'b1;
						res.path_done = 1'b1;
					end else if (tok.cls == CL_DOT || tok.cls == CL_LBRACK) begin
						res.key_done = 1'b1;
					end else if (key_ok) begin
						res.key_byte_valid = 1'b1;
						res.key_char       = tok.ch;
					end else begin
						res.error_code = ERR_BAD_KEY_CHAR;
					end
				end
				default: begin
					if (is_end) begin
						res.path_done = 1'b1;
					end else if (tok.cls != CL_DOT) begin
						res.error_code = ERR_FIRST_NOT_DOT;
					end
				end
			endcase
			if (res.error_code != ERR_NONE) begin
				res.path_done = is_end;
			end
		end
	end

	always_comb begin
		parse_state_t st;
		st      = state_q;
		state_d = state_q;
		held_d  = held_q;
		if (tok_take) begin
			if (held_q != ERR_NONE) begin
				if (is_end) begin
					held_d  = ERR_NONE;
					state_d = ST_EMPTY_ROOT;
				end
			end else begin
				unique case (state_q)
					ST_DOT_ROOT: begin
						if (tok.cls == CL_LBRACK) begin
							st = ST_PART_ARRAY;
						end else if (key_ok) begin
							st = ST_WITHIN_KEY;
						end
					end
					ST_PART_ARRAY: begin
						if (tok.cls == CL_RBRACK) begin
							st = ST_FULL_ARRAY;
						end
					end
					ST_FULL_ARRAY, ST_WITHIN_KEY: begin
						if (tok.cls == CL_DOT) begin
							st = ST_START_KEY;
						end else if (tok.cls == CL_LBRACK) begin
							st = ST_PART_ARRAY;
						end
					end
					ST_START_KEY: begin
						if (key_ok) begin
							st = ST_WITHIN_KEY;
						end
					end
					default: begin
						if (tok.cls == CL_DOT) begin
							st = ST_DOT_ROOT;
						end
					end
				endcase
				if (is_end) begin
					state_d = ST_EMPTY_ROOT;
				end else if (res.error_code != ERR_NONE) begin
					held_d  = res.error_code;
					state_d = st;
				end else begin
					state_d = st;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take) begin
			oq_q[owr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EMPTY_ROOT;
			held_q    <= ERR_NONE;
			owr_ptr_q <= 1'b0;
			ord_ptr_q <= 1'b0;
			ocnt_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			if (tok_take) begin
				owr_ptr_q <= !owr_ptr_q;
			end
			if (rd) begin
				ord_ptr_q <= !ord_ptr_q;
			end
			case ({tok_take, rd})
				2'b10:   ocnt_q <= ocnt_q + 2'd1;
				2'b01:   ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	a_held_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && held_q != ERR_NONE && !is_end |=> held_q == $past(held_q))
		else $error("held error changed before end of path");

	a_end_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && is_end |=> state_q == ST_EMPTY_ROOT && held_q == ERR_NONE)
		else $error("end of path did not return parser to root");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_take |=> state_q == $past(state_q) && held_q == $past(held_q))
		else $error("parser state moved without a request");

	a_err_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && res.error_code != ERR_NONE
		|-> !(res.key_byte_valid || res.key_done || res.array_segment))
		else $error("segment event reported with an error");

endmodule

/* rtl/json_value_path_tokenizer.sv */
// Checks a JSON value path such as ".a.b[][].c" one byte per request, with a
// separate end-of-path request closing each path, and gives exactly one result
// per request: key bytes passed through, key end, "[]" segment, path end, and
// an error code that sticks until end of path. Throughput is one request per
// clock while full is low; the parse state in the back end is updated once per
// request. A request is held in the two-entry classified-byte queue until the
// back end parses it into the two-entry result queue, from which its result is
// popped. full rises only when the result queue is full and the
// classified-byte queue cannot drain.
module json_value_path_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       path_end,
	output logic       empty,
	input  logic       pop,
	output logic       key_byte_valid,
	output logic [7:0] key_char,
	output logic       key_done,
	output logic       array_segment,
	output logic       path_done,
	output logic [2:0] error_code
);
	import jvpt_pkg::*;

	token_t  tok;
	logic    tok_valid;
	logic    tok_take;
	result_t res_out;

	jvpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.path_end  (path_end),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_take  (tok_take)
	);

	jvpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_take  (tok_take),
		.empty     (empty),
		.pop       (pop),
		.res_out   (res_out)
	);

	assign key_byte_valid = res_out.key_byte_valid;
	assign key_char       = res_out.key_char;
	assign key_done       = res_out.key_done;
	assign array_segment  = res_out.array_segment;
	assign path_done      = res_out.path_done;
	assign error_code     = res_out.error_code;

endmodule
